### rtl/afcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_pkg: shared types and constants
// Payload structs, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package afcr_pkg;

   localparam int RING_DEPTH     = 4096;
   localparam int RING_AW        = $clog2(RING_DEPTH);
   localparam int CNT_W          = RING_AW + 1;
   localparam int SKIP_FRAMES    = 128;
   localparam int NEAR_FULL_FREE = 16;
   localparam int RESUME_FREE    = 512;
   localparam int RESUME_LIM     = (RESUME_FREE < RING_DEPTH) ? RESUME_FREE : RING_DEPTH;

   localparam logic [1:0] CSR_RESAMPLE_ENABLE = 2'd0;
   localparam logic [1:0] CSR_PHASE_INCREMENT = 2'd1;
   localparam logic [1:0] CSR_DROP_ON_OVERRUN = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic              operation;
      logic signed [15:0] in_left;
      logic signed [15:0] in_right;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_left;
      logic signed [15:0] out_right;
      logic               done_res;
      logic               underrun;
      logic               writer_hold;
      logic [12:0]        fill_level;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ_DIRECT,
      ST_CUBIC1,
      ST_CUBIC2,
      ST_CUBIC3,
      ST_CUBIC4,
      ST_POP_ADDR,
      ST_POP_DATA,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load_req;    // capture request payload
      logic do_write;    // store frame, handle near-full
      logic direct_read; // pop or repeat into output
      logic cubic_load;  // coefficients, start phase
      logic cubic_s1;
      logic cubic_s2;
      logic cubic_s3;
      logic cubic_out;
      logic pop_addr;    // present read address
      logic pop_shift;   // shift popped or repeated frame
      logic finish;      // hold update, build response
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic resample;
      logic pops_left;
   } status_type;

endpackage

### rtl/afcr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_datapath: ring memory, history, phase and cubic arithmetic
// Each channel runs the cubic as three multiply-add steps, one per cycle.
// ----------------------------------------------------------------------------
module afcr_datapath
   import afcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  req_type     req_payload,
   input  logic        resample_enable,
   input  logic [17:0] phase_increment,
   input  logic        drop_on_overrun,
   output rsp_type     rsp_data
);

   logic [31:0]        ring_mem [RING_DEPTH];
   logic [31:0]        rd_data_ff;
   logic [RING_AW-1:0] rd_addr;

   req_type            req_ff;
   logic [RING_AW-1:0] wr_idx_ff, wr_idx_in;
   logic [RING_AW-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [31:0]        hist_ff [4];
   logic [31:0]        hist_in [4];
   logic [15:0]        phase_ff, phase_in;
   logic [2:0]         pops_ff, pops_in;
   logic               hold_ff, hold_in;
   logic               done_ff, done_in;
   logic               under_ff, under_in;
   logic [31:0]        out_frame_ff, out_frame_in;
   rsp_type            rsp_ff, rsp_in;
   logic               ring_we;

   // phase used by the cubic, captured before the advance
   logic [15:0]        phase_ff_old, phase_old_in;

   // per-channel arithmetic registers: index 0 left, 1 right
   logic signed [19:0] ca_ff [2], cb_ff [2], cc_ff [2], cd_ff [2];
   logic signed [19:0] ca_in [2], cb_in [2], cc_in [2], cd_in [2];
   logic signed [47:0] acc_ff [2], acc_in [2];

   function automatic logic signed [47:0] qtrunc(input logic signed [64:0] v);
      logic signed [64:0] t;
      t = v;
      if (v < 0) t = v + 65'sd65535;
      return t[63:16];
   endfunction

   // s3 * 45 / 6553600 toward zero: times 9, drop 18 bits, divide by 5
   function automatic logic [15:0] finish_s(input logic signed [47:0] s3);
      logic        neg;
      logic [47:0] mag;
      logic [51:0] m9;
      logic [23:0] t;
      logic [43:0] r;
      logic [19:0] qm;
      neg = s3[47];
      mag = neg ? -s3 : s3;
      m9  = {4'd0, mag} + {1'b0, mag, 3'b000};
      t   = m9[41:18];
      r   = {20'd0, t} * {24'd0, 20'd838861};
      qm  = r[41:22];
      if (!neg && qm > 20'd32767) return 16'h7FFF;
      if (neg && qm > 20'd32768) return 16'h8000;
      return neg ? (16'd0 - qm[15:0]) : qm[15:0];
   endfunction

   assign rd_addr = rd_idx_ff;

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wr_idx_ff] <= {req_ff.in_right, req_ff.in_left};
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   always_comb begin
      logic [CNT_W-1:0] n;
      logic [CNT_W-1:0] cnt;
      logic [RING_AW-1:0] ri;
      logic [18:0] ph;
      logic signed [19:0] x [4];
      logic signed [64:0] prod;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      count_in     = count_ff;
      hist_in      = hist_ff;
      phase_in     = phase_ff;
      pops_in      = pops_ff;
      hold_in      = hold_ff;
      done_in      = done_ff;
      under_in     = under_ff;
      out_frame_in = out_frame_ff;
      rsp_in       = rsp_ff;
      ca_in = ca_ff; cb_in = cb_ff; cc_in = cc_ff; cd_in = cd_ff;
      acc_in       = acc_ff;
      ring_we      = 1'b0;
      n = '0; cnt = count_ff; ri = rd_idx_ff; ph = '0; prod = '0;
      for (int k = 0; k < 4; k++) x[k] = '0;

      if (cmd.load_req) begin
         done_in = 1'b1;
         under_in = 1'b0;
         out_frame_in = '0;
      end

      if (cmd.do_write) begin
         cnt = count_ff;
         ri  = rd_idx_ff;
         if (cnt >= CNT_W'(RING_DEPTH) && drop_on_overrun) begin
            n = (cnt > CNT_W'(SKIP_FRAMES)) ? CNT_W'(SKIP_FRAMES) : cnt;
            ri = ri + n[RING_AW-1:0];
            cnt = cnt - n;
         end
         if (cnt >= CNT_W'(RING_DEPTH)) begin
            done_in = 1'b0;
         end else begin
            ring_we = 1'b1;
            wr_idx_in = wr_idx_ff + 1'b1;
            cnt = cnt + 1'b1;
         end
         if (CNT_W'(RING_DEPTH) - cnt < CNT_W'(NEAR_FULL_FREE)) begin
            if (drop_on_overrun) begin
               n = (cnt > CNT_W'(SKIP_FRAMES)) ? CNT_W'(SKIP_FRAMES) : cnt;
               ri = ri + n[RING_AW-1:0];
               cnt = cnt - n;
            end else begin
               hold_in = 1'b1;
            end
         end
         rd_idx_in = ri;
         count_in  = cnt;
      end

      if (cmd.direct_read) begin
         if (count_ff == '0) begin
            out_frame_in = hist_ff[3];
            done_in = 1'b0;
            under_in = 1'b1;
         end else begin
            out_frame_in = rd_data_ff;
            hist_in[0] = hist_ff[1]; hist_in[1] = hist_ff[2];
            hist_in[2] = hist_ff[3]; hist_in[3] = rd_data_ff;
            rd_idx_in = rd_idx_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
      end

      if (cmd.cubic_load) begin
         if (count_ff == '0) done_in = 1'b0;
         ph = {3'b000, phase_ff} + {1'b0, phase_increment};
         pops_in = ph[18:16];
         phase_in = ph[15:0];
         for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < 4; k++) begin
               x[k] = 20'(signed'(hist_ff[k][16*c +: 16]));
            end
            ca_in[c] = 20'(x[1] <<< 1);
            cb_in[c] = x[2] - x[0];
            cc_in[c] = (x[0] <<< 1) - (x[1] <<< 2) - x[1] + (x[2] <<< 2) - x[3];
            cd_in[c] = x[1] + (x[1] <<< 1) - x[2] - (x[2] <<< 1) + x[3] - x[0];
         end
      end

      // s1 = c*65536 + d*p
      if (cmd.cubic_s1) begin
         for (int c = 0; c < 2; c++) begin
            acc_in[c] = (48'(cc_ff[c]) <<< 16)
                      + 48'(cd_ff[c]) * $signed({32'd0, phase_ff_old});
         end
      end
      if (cmd.cubic_s2) begin
         for (int c = 0; c < 2; c++) begin
            prod = 65'(acc_ff[c]) * $signed({49'd0, phase_ff_old});
            acc_in[c] = (48'(cb_ff[c]) <<< 16) + qtrunc(prod);
         end
      end
      if (cmd.cubic_s3) begin
         for (int c = 0; c < 2; c++) begin
            prod = 65'(acc_ff[c]) * $signed({49'd0, phase_ff_old});
            acc_in[c] = (48'(ca_ff[c]) <<< 16) + qtrunc(prod);
         end
      end
      if (cmd.cubic_out) begin
         out_frame_in = {finish_s(acc_ff[1]), finish_s(acc_ff[0])};
      end

      if (cmd.pop_shift) begin
         pops_in = pops_ff - 1'b1;
         hist_in[0] = hist_ff[1]; hist_in[1] = hist_ff[2]; hist_in[2] = hist_ff[3];
         if (count_ff == '0) begin
            hist_in[3] = hist_ff[3];
            under_in = 1'b1;
         end else begin
            hist_in[3] = rd_data_ff;
            rd_idx_in = rd_idx_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
      end

      // a write that just set hold leaves free space under the release level
      if (cmd.finish) begin
         if (CNT_W'(RING_DEPTH) - count_ff >= CNT_W'(RESUME_LIM)) hold_in = 1'b0;
         rsp_in.out_left    = out_frame_ff[15:0];
         rsp_in.out_right   = out_frame_ff[31:16];
         rsp_in.done_res    = done_ff;
         rsp_in.underrun    = under_ff;
         rsp_in.fill_level  = 13'(count_ff);
         rsp_in.writer_hold = hold_in;
      end
   end

   assign phase_old_in = cmd.cubic_load ? phase_ff : phase_ff_old;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= '0;
         hold_ff   <= 1'b0;
         for (int k = 0; k < 4; k++) hist_ff[k] <= '0;
         pops_ff   <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         hold_ff   <= hold_in;
         hist_ff   <= hist_in;
         pops_ff   <= pops_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_payload;
      done_ff      <= done_in;
      under_ff     <= under_in;
      out_frame_ff <= out_frame_in;
      rsp_ff       <= rsp_in;
      ca_ff <= ca_in; cb_ff <= cb_in; cc_ff <= cc_in; cd_ff <= cd_in;
      acc_ff       <= acc_in;
      phase_ff_old <= phase_old_in;
   end

   assign status.is_read   = req_ff.operation == OP_READ;
   assign status.resample  = resample_enable;
   assign status.pops_left = pops_ff != '0;
   assign rsp_data         = rsp_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RING_DEPTH))
      else $error("fill count beyond ring depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_idx_ff - rd_idx_ff) == count_ff[RING_AW-1:0])
      else $error("ring indexes disagree with fill count");
   a_pops_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_shift |-> pops_ff != '0)
      else $error("pop issued with no pops pending");
`endif

endmodule

### rtl/afcr_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_controller: sequencer for write, direct read and resampled read
// Issues at most one datapath command per state and runs the handshakes.
// ----------------------------------------------------------------------------
module afcr_controller
   import afcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // rd data for the head is valid from here on
            if (!status.is_read) begin
               cmd.do_write = 1'b1;
               state_in = ST_FINISH;
            end else if (status.resample) begin
               state_in = ST_CUBIC1;
               cmd.cubic_load = 1'b1;
            end else begin
               state_in = ST_READ_DIRECT;
            end
         end
         ST_READ_DIRECT: begin
            cmd.direct_read = 1'b1;
            state_in = ST_FINISH;
         end
         ST_CUBIC1: begin
            cmd.cubic_s1 = 1'b1;
            state_in = ST_CUBIC2;
         end
         ST_CUBIC2: begin
            cmd.cubic_s2 = 1'b1;
            state_in = ST_CUBIC3;
         end
         ST_CUBIC3: begin
            cmd.cubic_s3 = 1'b1;
            state_in = ST_CUBIC4;
         end
         ST_CUBIC4: begin
            cmd.cubic_out = 1'b1;
            state_in = ST_POP_ADDR;
         end
         ST_POP_ADDR: begin
            // wait here for the registered ring read
            cmd.pop_addr = 1'b1;
            state_in = status.pops_left ? ST_POP_DATA : ST_FINISH;
         end
         ST_POP_DATA: begin
            cmd.pop_shift = 1'b1;
            state_in = ST_POP_ADDR;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before taken");
   a_finish_then_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finish not followed by response");
`endif

endmodule

### rtl/audio_fifo_catmull_resampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_fifo_catmull_resampler_core: stereo frame FIFO with cubic resampler
// Channel   Ports                      Payload
// req       req_valid / req_ready      req_type  (operation, in_left, in_right)
// rsp       rsp_valid / rsp_ready      rsp_type  (samples, flags, fill level)
// csr       csr_valid / csr_ready      csr_index, csr_wdata (always ready)
// Before the response a write passes the write and finish states, a direct read
// adds the read state, and a resampled read adds the four cubic steps and, per
// frame popped (0 to 4), an address and a data state for the registered ring read.
// One transaction at a time; rsp_valid holds until taken and req_ready
// returns the cycle after the response is taken.
// Reset is synchronous; the ring holds no reset value.
// ----------------------------------------------------------------------------
module audio_fifo_catmull_resampler_core
   import afcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [17:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic        resample_enable_ff;
   logic [17:0] phase_increment_ff;
   logic        drop_on_overrun_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         resample_enable_ff <= 1'b0;
         phase_increment_ff <= 18'd65536;
         drop_on_overrun_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RESAMPLE_ENABLE: resample_enable_ff <= csr_wdata[0];
            CSR_PHASE_INCREMENT: phase_increment_ff <= csr_wdata;
            CSR_DROP_ON_OVERRUN: drop_on_overrun_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   afcr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   afcr_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_payload     (req_data),
      .resample_enable (resample_enable_ff),
      .phase_increment (phase_increment_ff),
      .drop_on_overrun (drop_on_overrun_ff),
      .rsp_data        (rsp_data)
   );

endmodule
